FILE: hw/rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg: shared definitions for the file block allocator
// Geometry constants, field widths, status codes and the command record that
// the front end hands to the back end through the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

	// Store geometry.
	localparam int NUM_DATA_BLOCKS  = 4096;
	localparam int FIRST_DATA_BLOCK = 129;
	localparam int BLOCK_BYTES      = 8192;
	localparam int MAX_SLOTS        = 128;
	localparam int BLOCKS_PER_SLOT  = 32;

	// Field widths of the ports.
	localparam int FB_W   = 19;  // file_bytes, max_file_bytes
	localparam int NC_W   = 8;   // name_chars
	localparam int MNC_W  = 6;   // max_name_chars
	localparam int BI_W   = 13;  // block_index
	localparam int SI_W   = 7;   // slot_index
	localparam int ST_W   = 3;   // status

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = FB_W;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FILE_BYTES = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_NAME_CHARS = CFG_IDX_W'(1);
	localparam logic [FB_W-1:0]  MAX_FILE_BYTES_RST = FB_W'(259072);
	localparam logic [MNC_W-1:0] MAX_NAME_CHARS_RST = MNC_W'(32);

	// Derived widths.
	localparam int BB_SHIFT = $clog2(BLOCK_BYTES);          // BLOCK_BYTES is a power of two
	localparam int NEED_W   = FB_W + 1 - BB_SHIFT;          // ceil(bytes / BLOCK_BYTES)
	localparam int BLK_W    = $clog2(NUM_DATA_BLOCKS + 1);  // block pointer incl. full mark
	localparam int SCNT_W   = $clog2(MAX_SLOTS + 1);        // slot count incl. full mark
	localparam int CMP_W    = (NEED_W > BLK_W) ? NEED_W : BLK_W;

	// Command queue depth (power of two).
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK        = ST_W'(0);
	localparam logic [ST_W-1:0] ST_NO_NAME   = ST_W'(1);
	localparam logic [ST_W-1:0] ST_NAME_LONG = ST_W'(2);
	localparam logic [ST_W-1:0] ST_DIR_FULL  = ST_W'(3);
	localparam logic [ST_W-1:0] ST_TOO_LARGE = ST_W'(4);
	localparam logic [ST_W-1:0] ST_NO_SPACE  = ST_W'(5);

	// One classified request. Failed requests carry zero blocks and slot zero.
	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [SI_W-1:0]   slot;
		logic [BLK_W-1:0]  base;   // first data block taken (relative)
		logic [NEED_W-1:0] need;   // number of data blocks taken
	} cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fba_front.sv
// ----------------------------------------------------------------------------
// fba_front: request classifier
// Holds the limit registers, the directory fill count and the block fill
// pointer, checks each store request in order, reserves the slot and blocks
// of a request that passes and queues a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [fba_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [fba_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic [fba_pkg::FB_W-1:0]      file_bytes,
	input  wire logic [fba_pkg::NC_W-1:0]      name_chars,
	output      logic                          push,
	output      fba_pkg::cmd_t                 push_cmd,
	input  wire logic                          queue_full
);
	import fba_pkg::*;

	logic [FB_W-1:0]   max_bytes_q;
	logic [MNC_W-1:0]  max_name_q;
	logic [SCNT_W-1:0] slot_cnt_q;   // slots are only ever taken, lowest first
	logic [BLK_W-1:0]  next_blk_q;   // blocks are only ever taken, lowest first

	logic [FB_W:0]     round_up;
	logic [NEED_W-1:0] need;
	logic [BLK_W-1:0]  free_total;
	logic              no_name;
	logic              name_long;
	logic              dir_full;
	logic              too_large;
	logic              no_space;

	// Block count, free count and the ordered checks.
	always_comb begin
		round_up   = {1'b0, file_bytes} + (FB_W + 1)'(BLOCK_BYTES - 1);
		need       = round_up[FB_W:BB_SHIFT];
		free_total = BLK_W'(NUM_DATA_BLOCKS) - next_blk_q;
		no_name    = (name_chars == '0);
		name_long  = (name_chars > NC_W'(max_name_q));
		dir_full   = (slot_cnt_q == SCNT_W'(MAX_SLOTS));
		too_large  = (file_bytes > max_bytes_q) ||
			(need > NEED_W'(BLOCKS_PER_SLOT));
		no_space   = (CMP_W'(need) > CMP_W'(free_total));
	end

	// Command build; a failed request carries no blocks and slot zero.
	always_comb begin
		push_cmd.status = ST_OK;
		if (no_name) begin
			push_cmd.status = ST_NO_NAME;
		end else if (name_long) begin
			push_cmd.status = ST_NAME_LONG;
		end else if (dir_full) begin
			push_cmd.status = ST_DIR_FULL;
		end else if (too_large) begin
			push_cmd.status = ST_TOO_LARGE;
		end else if (no_space) begin
			push_cmd.status = ST_NO_SPACE;
		end
		push_cmd.slot = '0;
		push_cmd.base = '0;
		push_cmd.need = '0;
		if (push_cmd.status == ST_OK) begin
			push_cmd.slot = slot_cnt_q[SI_W-1:0];
			push_cmd.base = next_blk_q;
			push_cmd.need = need;
		end
	end

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	// Limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_FILE_BYTES_RST;
			max_name_q  <= MAX_NAME_CHARS_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_MAX_FILE_BYTES: max_bytes_q <= cfg_wdata[FB_W-1:0];
				REG_MAX_NAME_CHARS: max_name_q  <= cfg_wdata[MNC_W-1:0];
				default: ;
			endcase
		end
	end

	// Reservation of the slot and the blocks of an accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_cnt_q <= '0;
			next_blk_q <= '0;
		end else if (push && (push_cmd.status == ST_OK)) begin
			slot_cnt_q <= slot_cnt_q + SCNT_W'(1);
			next_blk_q <= next_blk_q + BLK_W'(need);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/fba_queue.sv
// ----------------------------------------------------------------------------
// fba_queue: command queue
// A short first-in first-out queue of classified commands between the front
// end and the back end; the head is visible without a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire fba_pkg::cmd_t push_cmd,
	output      logic          full,
	input  wire logic          pop,
	output      fba_pkg::cmd_t head,
	output      logic          empty
);
	import fba_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/fba_back.sv
// ----------------------------------------------------------------------------
// fba_back: result sequencer
// Walks the head command one block per cycle unless the output stalls, loads
// each result into the output register and pops the command with its last result.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire fba_pkg::cmd_t           head,
	input  wire logic                    empty,
	output      logic                    pop,
	output      logic                    out_valid,
	input  wire logic                    out_ready,
	output      logic [fba_pkg::BI_W-1:0] block_index,
	output      logic                    block_valid,
	output      logic [fba_pkg::SI_W-1:0] slot_index,
	output      logic [fba_pkg::ST_W-1:0] status,
	output      logic                    last
);
	import fba_pkg::*;

	logic [NEED_W-1:0] blk_cnt_q;   // block of the head command to emit next
	logic              out_valid_q;
	logic [BI_W-1:0]   block_index_q;
	logic              block_valid_q;
	logic [SI_W-1:0]   slot_index_q;
	logic [ST_W-1:0]   status_q;
	logic              last_q;

	logic              load;
	logic              has_blk;
	logic              is_last;
	logic [NEED_W:0]   cnt_next;
	logic [BI_W-1:0]   abs_idx;

	// Next result of the head command.
	always_comb begin
		load     = !empty && (!out_valid_q || out_ready);
		has_blk  = (head.need != '0);
		cnt_next = {1'b0, blk_cnt_q} + (NEED_W + 1)'(1);
		is_last  = !has_blk || (cnt_next == {1'b0, head.need});
		abs_idx  = BI_W'(FIRST_DATA_BLOCK) + BI_W'(head.base) + BI_W'(blk_cnt_q);
	end

	assign pop = load && is_last;

	// Block counter within the head command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_cnt_q <= '0;
		end else if (load) begin
			blk_cnt_q <= is_last ? '0 : cnt_next[NEED_W-1:0];
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			block_index_q <= has_blk ? abs_idx : '0;
			block_valid_q <= has_blk;
			slot_index_q  <= head.slot;
			status_q      <= head.status;
			last_q        <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign block_index = block_index_q;
	assign block_valid = block_valid_q;
	assign slot_index  = slot_index_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/file_block_allocator.sv
// ----------------------------------------------------------------------------
// file_block_allocator: first-fit data block allocator for a flat file store
// Classifies store requests, takes a directory slot and the lowest free data
// blocks, and emits one result per block taken (one if none), the last one marked.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   in        in_valid/in_ready     file_bytes, name_chars
//   out       out_valid/out_ready   block_index, block_valid, slot_index,
//                                   status, last
//   cfg       cfg_wen               cfg_idx, cfg_wdata (write only)
//
// The front end takes one request per cycle while the two-entry command queue
// has room. The back end emits one result per cycle unless the output stalls;
// a request yields max(blocks, 1) results (1 to 32); the result sequencer sets the rate.
// Blocks and slots are only ever taken, lowest first, so the free map and the
// directory valid bits reduce to two fill counters; reset clears them at once,
// and there is no clearing pass. A stalled output holds its result while the
// front end keeps accepting into the queue until both entries are taken; then
// in_ready drops until the back end pops a command.
`default_nettype none

module file_block_allocator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [fba_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [fba_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           in_valid,
	output      logic                           in_ready,
	input  wire logic [fba_pkg::FB_W-1:0]       file_bytes,
	input  wire logic [fba_pkg::NC_W-1:0]       name_chars,
	output      logic                           out_valid,
	input  wire logic                           out_ready,
	output      logic [fba_pkg::BI_W-1:0]       block_index,
	output      logic                           block_valid,
	output      logic [fba_pkg::SI_W-1:0]       slot_index,
	output      logic [fba_pkg::ST_W-1:0]       status,
	output      logic                           last
);
	import fba_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic pop;
	cmd_t head;
	logic empty;

	// Request classification and reservation.
	fba_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.file_bytes (file_bytes),
		.name_chars (name_chars),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	// Command queue between the two halves.
	fba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	// Result sequencing and output register.
	fba_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.block_index (block_index),
		.block_valid (block_valid),
		.slot_index  (slot_index),
		.status      (status),
		.last        (last)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/fba_checker.sv
// ----------------------------------------------------------------------------
// fba_checker: port-level checks for the file block allocator
// Watches the result channel of the top level and flags results that break
// the output contract.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic [fba_pkg::BI_W-1:0] block_index,
	input wire logic                     block_valid,
	input wire logic [fba_pkg::SI_W-1:0] slot_index,
	input wire logic [fba_pkg::ST_W-1:0] status,
	input wire logic                     last
);
	import fba_pkg::*;

	// A stalled result holds valid and payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(block_index) &&
		$stable(block_valid) && $stable(slot_index) && $stable(status) &&
		$stable(last))
		else $error("result changed while stalled");

	// A result without a block is always the only, and so last, one.
	a_noblk_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !block_valid |-> last && (block_index == '0))
		else $error("blockless result not last or index not zero");

	// A failed request reports no block and slot zero.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> !block_valid && (slot_index == '0))
		else $error("failed request carries a block or a slot");

	// Consecutive blocks of one request come from one slot, in rising order.
	a_blk_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && block_valid && !last ##1 out_valid |->
		block_valid && (block_index > $past(block_index)) &&
		(slot_index == $past(slot_index)))
		else $error("blocks of one request out of order");

endmodule

bind file_block_allocator fba_checker u_fba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.block_index (block_index),
	.block_valid (block_valid),
	.slot_index  (slot_index),
	.status      (status),
	.last        (last)
);

`default_nettype wire
